FILE: rtl/core/set_assoc_writeback_cache_assert.svh
// Assertion macros used by the cache datapath.
`ifndef SET_ASSOC_WRITEBACK_CACHE_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_CACHE_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define SAWBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define SAWBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sawbc_pkg.sv
// Package: types, constants and command/status structs of the cache.
`timescale 1ns / 1ps
`default_nettype none
package sawbc_pkg;

  localparam int ADDR_W      = 16;
  localparam int OFF_W       = 3;
  localparam int SET_W       = 4;
  localparam int SET_COUNT   = 16;
  localparam int TAG_W       = ADDR_W - OFF_W - SET_W;
  localparam int BLOCK_W     = ADDR_W - OFF_W;
  localparam int LINE_BYTES  = 8;
  localparam int LINE_W      = LINE_BYTES * 8;
  localparam int MEM_LINES   = 8192;
  localparam int WAY_COUNT   = 4;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              operation;
    logic [7:0]        write_byte;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] read_address;
    logic [LINE_W-1:0] line_bytes;
    logic              hit;
    logic              dirty;
  } out_word_t;

  typedef struct packed {
    logic accept;     // latch request, read tag word
    logic lookup;     // compare tags, pick way, read line
    logic wb_wr;      // write victim line to backing memory
    logic fill_rd;    // read requested block from backing memory
    logic apply;      // update line, tag and bookkeeping
    logic resp_load;  // load result word
    logic clr_wr;     // backing memory clearing pass
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic need_wb;
    logic is_write;
    logic out_busy;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/set_assoc_writeback_cache.sv
// Top level of the 4-way set-associative write-back cache.
`timescale 1ns / 1ps
`default_nettype none
// 4-way, 16-set write-back, write-allocate cache with 8-byte lines and LRU replacement
// in front of a 64 KiB backing memory. After reset the block clears the backing
// memory, one line per cycle, with in_ready low. Accesses are handled one at a time
// on single-port memories. A read passes through the lookup, apply and response
// states; a write hit through lookup and apply. A miss adds a fill read state. A
// dirty victim adds a write-back state as well, since the victim write-back and the
// fill share the one backing memory port. A read gives one result word; a write gives
// none. A finished result waits in the output register while the next word is
// accepted. A later read stays in its response state while that result is not taken.
module set_assoc_writeback_cache #(
  parameter int WAY_COUNT = sawbc_pkg::WAY_COUNT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire sawbc_pkg::in_word_t  in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      sawbc_pkg::out_word_t out_data
);

  sawbc_pkg::cmd_t cmd;
  sawbc_pkg::sts_t sts;

  sawbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  sawbc_dp #(.WAY_COUNT(WAY_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/core/sawbc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sawbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sawbc_ctrl.sv
// Cache controller: access sequencing state machine.
`timescale 1ns / 1ps
`default_nettype none
module sawbc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire sawbc_pkg::sts_t sts,
  output      sawbc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_WB, ST_FILLRD, ST_APPLY, ST_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        priority if (sts.hit) state_nxt = ST_APPLY;
        else if (sts.need_wb) state_nxt = ST_WB;
        else state_nxt = ST_FILLRD;
      end
      ST_WB: begin
        cmd.wb_wr = 1'b1;
        state_nxt = ST_FILLRD;
      end
      ST_FILLRD: begin
        cmd.fill_rd = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = sts.is_write ? ST_IDLE : ST_RESP;
      end
      ST_RESP: begin
        if (!sts.out_busy) begin
          cmd.resp_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sawbc_dp.sv
// Cache datapath: tag/line/backing memories, replacement state, result register.
`timescale 1ns / 1ps
`default_nettype none
module sawbc_dp #(
  parameter int WAY_COUNT = sawbc_pkg::WAY_COUNT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sawbc_pkg::in_word_t  in_data,
  input  wire sawbc_pkg::cmd_t      cmd,
  output      sawbc_pkg::sts_t      sts,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      sawbc_pkg::out_word_t out_data
);

  localparam int TAG_W   = sawbc_pkg::TAG_W;
  localparam int SET_W   = sawbc_pkg::SET_W;
  localparam int SETS    = sawbc_pkg::SET_COUNT;
  localparam int LINE_W  = sawbc_pkg::LINE_W;
  localparam int BLOCK_W = sawbc_pkg::BLOCK_W;
  localparam int OFF_W   = sawbc_pkg::OFF_W;
  localparam int WAY_W   = $clog2(WAY_COUNT);
  localparam int SLOTS   = SETS * WAY_COUNT;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int TWORD_W = WAY_COUNT * TAG_W;

  sawbc_pkg::in_word_t  req_r;
  sawbc_pkg::out_word_t out_r;
  logic                 out_valid_r;

  logic [SET_W-1:0]   set_q;
  logic [TAG_W-1:0]   tag_q;
  logic [OFF_W-1:0]   off_q;
  logic [BLOCK_W-1:0] block_q;
  assign off_q   = req_r.address[OFF_W-1:0];
  assign set_q   = req_r.address[OFF_W +: SET_W];
  assign tag_q   = req_r.address[OFF_W+SET_W +: TAG_W];
  assign block_q = req_r.address[OFF_W +: BLOCK_W];

  logic             valid_r [SETS][WAY_COUNT];
  logic             dirty_r [SETS][WAY_COUNT];
  logic [WAY_W-1:0] rank_r  [SETS][WAY_COUNT];

  logic [WAY_W-1:0]   way_r;
  logic               hit_r, wb_r, was_valid_r, res_dirty_r;
  logic [TAG_W-1:0]   vtag_r;
  logic [LINE_W-1:0]  line_r;
  logic [BLOCK_W-1:0] clr_cnt_r;

  // tag memory: one word per set, all ways side by side
  logic [TWORD_W-1:0] tag_rdata, tag_wdata;
  logic [SET_W-1:0]   tag_addr;
  assign tag_addr = cmd.accept ? in_data.address[OFF_W +: SET_W] : set_q;

  sawbc_ram #(.WIDTH(TWORD_W), .DEPTH(SETS)) u_tag_ram (
    .clk(clk), .we(cmd.apply), .re(cmd.accept), .addr(tag_addr),
    .wdata(tag_wdata), .rdata(tag_rdata)
  );

  // way selection during lookup
  logic             hit_c, inv_found_c;
  logic [WAY_W-1:0] hit_way_c, inv_way_c, lru_way_c, way_c;
  logic [WAY_W-1:0] best_c;

  always_comb begin
    hit_c = 1'b0;
    hit_way_c = '0;
    inv_found_c = 1'b0;
    inv_way_c = '0;
    lru_way_c = '0;
    best_c = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!hit_c && valid_r[set_q][w] && tag_rdata[w*TAG_W +: TAG_W] == tag_q) begin
        hit_c = 1'b1;
        hit_way_c = WAY_W'(w);
      end
      if (!inv_found_c && !valid_r[set_q][w]) begin
        inv_found_c = 1'b1;
        inv_way_c = WAY_W'(w);
      end
      if (rank_r[set_q][w] > best_c) begin
        best_c = rank_r[set_q][w];
        lru_way_c = WAY_W'(w);
      end
    end
    priority if (hit_c) way_c = hit_way_c;
    else if (inv_found_c) way_c = inv_way_c;
    else way_c = lru_way_c;
  end

  logic need_wb_c;
  assign need_wb_c = !hit_c && valid_r[set_q][way_c] && dirty_r[set_q][way_c];

  // line memory
  logic [SLOT_W-1:0] slot_c, slot_q, data_addr;
  logic [LINE_W-1:0] data_rdata, line_new;
  assign slot_c    = SLOT_W'(int'(set_q) * WAY_COUNT + int'(way_c));
  assign slot_q    = SLOT_W'(int'(set_q) * WAY_COUNT + int'(way_r));
  assign data_addr = cmd.lookup ? slot_c : slot_q;

  sawbc_ram #(.WIDTH(LINE_W), .DEPTH(SLOTS)) u_data_ram (
    .clk(clk), .we(cmd.apply), .re(cmd.lookup), .addr(data_addr),
    .wdata(line_new), .rdata(data_rdata)
  );

  // backing memory
  logic [BLOCK_W-1:0] mem_addr;
  logic [LINE_W-1:0]  mem_rdata, mem_wdata;
  always_comb begin
    priority if (cmd.clr_wr) mem_addr = clr_cnt_r;
    else if (cmd.wb_wr) mem_addr = {vtag_r, set_q};
    else mem_addr = block_q;
  end
  assign mem_wdata = cmd.clr_wr ? '0 : data_rdata;

  sawbc_ram #(.WIDTH(LINE_W), .DEPTH(sawbc_pkg::MEM_LINES)) u_mem_ram (
    .clk(clk), .we(cmd.clr_wr | cmd.wb_wr), .re(cmd.fill_rd), .addr(mem_addr),
    .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // line after the access: byte lane offset*8 takes the write byte
  logic [LINE_W-1:0] line_src;
  always_comb begin
    line_src = hit_r ? data_rdata : mem_rdata;
    line_new = line_src;
    if (req_r.operation == sawbc_pkg::OP_WRITE) begin
      for (int b = 0; b < sawbc_pkg::LINE_BYTES; b++) begin
        if (OFF_W'(b) == off_q) line_new[b*8 +: 8] = req_r.write_byte;
      end
    end
  end

  always_comb begin
    tag_wdata = tag_rdata;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (WAY_W'(w) == way_r) tag_wdata[w*TAG_W +: TAG_W] = tag_q;
    end
  end

  // recency: an invalid way counts as older than all
  logic [WAY_W:0] old_rank;
  assign old_rank = was_valid_r ? {1'b0, rank_r[set_q][way_r]} : (WAY_W+1)'(WAY_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAY_COUNT; w++) begin
          valid_r[s][w] <= 1'b0;
          dirty_r[s][w] <= 1'b0;
          rank_r[s][w]  <= '0;
        end
      end
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.apply) begin
        for (int w = 0; w < WAY_COUNT; w++) begin
          if (WAY_W'(w) != way_r && valid_r[set_q][w] &&
              {1'b0, rank_r[set_q][w]} < old_rank) begin
            rank_r[set_q][w] <= rank_r[set_q][w] + 1'b1;
          end
        end
        rank_r[set_q][way_r]  <= '0;
        valid_r[set_q][way_r] <= 1'b1;
        dirty_r[set_q][way_r] <= (req_r.operation == sawbc_pkg::OP_WRITE) ||
                                 (hit_r && dirty_r[set_q][way_r]);
      end
      if (cmd.resp_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) req_r <= in_data;
    if (cmd.lookup) begin
      way_r       <= way_c;
      hit_r       <= hit_c;
      wb_r        <= need_wb_c;
      was_valid_r <= valid_r[set_q][way_c];
      vtag_r      <= tag_rdata[way_c*TAG_W +: TAG_W];
      res_dirty_r <= hit_c ? dirty_r[set_q][way_c] : need_wb_c;
    end
    if (cmd.apply) line_r <= line_new;
    if (cmd.resp_load) begin
      out_r.read_address <= req_r.address;
      out_r.line_bytes   <= line_r;
      out_r.hit          <= hit_r;
      out_r.dirty        <= res_dirty_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.hit      = hit_c;
  assign sts.need_wb  = need_wb_c;
  assign sts.is_write = (req_r.operation == sawbc_pkg::OP_WRITE);
  assign sts.out_busy = out_valid_r && !out_ready;
  assign sts.clr_last = (clr_cnt_r == {BLOCK_W{1'b1}});

  `include "set_assoc_writeback_cache_assert.svh"

  `SAWBC_ASSERT_IMP(a_resp_free, cmd.resp_load, !out_valid_r || out_ready, "result overwritten")
  `SAWBC_ASSERT_NXT(a_apply_valid, cmd.apply, valid_r[set_q][way_r] && rank_r[set_q][way_r] == '0, "used way not valid and most recent")
  `SAWBC_ASSERT_NXT(a_write_dirty, cmd.apply && sts.is_write, dirty_r[set_q][way_r], "written line not dirty")
  `SAWBC_ASSERT_IMP(a_wb_miss, cmd.wb_wr, !hit_r && wb_r, "write-back without dirty victim")

endmodule
`default_nettype wire

FILE: verif/tb_set_assoc_writeback_cache.sv
// Testbench for the set-associative write-back cache: directed table, random traffic, LRU predictor.
`timescale 1ns / 1ps
module tb_set_assoc_writeback_cache;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RANDOM_WORDS   = 1200;
  localparam int ADDR_W         = sawbc_pkg::ADDR_W;
  localparam int OFF_W          = sawbc_pkg::OFF_W;
  localparam int SET_W          = sawbc_pkg::SET_W;
  localparam int TAG_W          = sawbc_pkg::TAG_W;
  localparam int BLOCK_W        = sawbc_pkg::BLOCK_W;
  localparam int LINE_W         = sawbc_pkg::LINE_W;
  localparam int MEM_LINES      = sawbc_pkg::MEM_LINES;
  localparam int WAY_COUNT      = sawbc_pkg::WAY_COUNT;
  localparam int SLOTS          = sawbc_pkg::SET_COUNT * WAY_COUNT;
  localparam logic OP_READ      = sawbc_pkg::OP_READ;
  localparam logic OP_WRITE     = sawbc_pkg::OP_WRITE;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  sawbc_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  sawbc_pkg::out_word_t out_data;

  set_assoc_writeback_cache DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // predictor state
  logic [TAG_W-1:0]  tag_mem [SLOTS];
  logic              valid_mem [SLOTS];
  logic              dirty_mem [SLOTS];
  logic [LINE_W-1:0] data_mem [SLOTS];
  logic [1:0]        rank_mem [SLOTS];
  logic [LINE_W-1:0] backing [MEM_LINES];

  sawbc_pkg::out_word_t read_results_q[$];
  int        mismatches;
  int        idle_pct;
  int        stall_pct;
  int        quiet_cycles;
  logic      timed_out;

  task automatic report_mismatch(input string what, input logic [LINE_W-1:0] got,
                                 input logic [LINE_W-1:0] want);
    $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic cache_access(input sawbc_pkg::in_word_t w);
    logic [BLOCK_W-1:0]   blk;
    logic [SET_W-1:0]     set;
    logic [TAG_W-1:0]     tag;
    int                   base, way, old_rank;
    logic                 hit, wb;
    sawbc_pkg::out_word_t r;
    blk  = w.address[ADDR_W-1:OFF_W];
    set  = blk[SET_W-1:0];
    tag  = blk[BLOCK_W-1:SET_W];
    base = set * WAY_COUNT;
    way  = -1;
    hit  = 1'b0;
    wb   = 1'b0;
    for (int i = 0; i < WAY_COUNT; i++)
      if (way < 0 && valid_mem[base+i] && tag_mem[base+i] == tag) way = i;
    if (way >= 0) begin
      hit = 1'b1;
      wb = dirty_mem[base+way];
      old_rank = rank_mem[base+way];
    end else begin
      for (int i = 0; i < WAY_COUNT; i++)
        if (way < 0 && !valid_mem[base+i]) way = i;
      if (way < 0) begin
        way = 0;
        for (int i = 1; i < WAY_COUNT; i++)
          if (rank_mem[base+i] > rank_mem[base+way]) way = i;
      end
      old_rank = valid_mem[base+way] ? rank_mem[base+way] : WAY_COUNT;
      if (valid_mem[base+way] && dirty_mem[base+way]) begin
        backing[{tag_mem[base+way], set}] = data_mem[base+way];
        wb = 1'b1;
      end
      data_mem[base+way]  = backing[blk];
      tag_mem[base+way]   = tag;
      valid_mem[base+way] = 1'b1;
      dirty_mem[base+way] = 1'b0;
    end
    for (int i = 0; i < WAY_COUNT; i++)
      if (i != way && valid_mem[base+i] && rank_mem[base+i] < old_rank)
        rank_mem[base+i] = rank_mem[base+i] + 2'd1;
    rank_mem[base+way] = 2'd0;
    if (w.operation == OP_WRITE) begin
      data_mem[base+way][w.address[OFF_W-1:0]*8 +: 8] = w.write_byte;
      dirty_mem[base+way] = 1'b1;
    end else begin
      r.read_address = w.address;
      r.line_bytes   = data_mem[base+way];
      r.hit          = hit;
      r.dirty        = wb;
      read_results_q.push_back(r);
    end
  endtask

  // directed rows; check_line enables a typed-in expected line
  typedef struct {
    sawbc_pkg::in_word_t w;
    logic                check_line;
    logic [LINE_W-1:0]   line;
  } directed_row_t;

  directed_row_t rows[$];

  task automatic add_row(input logic [ADDR_W-1:0] a, input logic op, input logic [7:0] b,
                         input logic chk, input logic [LINE_W-1:0] line);
    directed_row_t r;
    r.w.address = a; r.w.operation = op; r.w.write_byte = b;
    r.check_line = chk; r.line = line;
    rows.push_back(r);
  endtask

  // valid stays high into the next word unless an idle cycle is drawn
  task automatic send_word(input sawbc_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cache_access(w);
  endtask

  function automatic sawbc_pkg::in_word_t random_word();
    sawbc_pkg::in_word_t w;
    int                  pick;
    pick = $urandom_range(99);
    // a few tags per set so that hits, evictions and write-backs all happen
    if (pick < 70)
      w.address = {7'd0, 2'($urandom_range(0, 7)), 4'($urandom), 3'($urandom)} ^
                  ($urandom_range(1) ? 16'hFF80 : 16'h0000);
    else
      w.address = 16'($urandom);
    w.operation  = 1'($urandom);
    w.write_byte = 8'($urandom);
    return w;
  endfunction

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (read_results_q.size() == 0) begin
        report_mismatch("unexpected read word", out_data.line_bytes, '0);
      end else begin
        sawbc_pkg::out_word_t e;
        e = read_results_q.pop_front();
        if (out_data.read_address !== e.read_address)
          report_mismatch("read_address", out_data.read_address, e.read_address);
        if (out_data.line_bytes !== e.line_bytes)
          report_mismatch("line_bytes", out_data.line_bytes, e.line_bytes);
        if (out_data.hit !== e.hit) report_mismatch("hit", out_data.hit, e.hit);
        if (out_data.dirty !== e.dirty) report_mismatch("dirty", out_data.dirty, e.dirty);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles without any handshake (the reset clearing pass counts as quiet)
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    sawbc_pkg::in_word_t w;
    int                  drain;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    mismatches = 0; idle_pct = 24; stall_pct = 24; quiet_cycles = 0; timed_out = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      tag_mem[i] = '0; valid_mem[i] = 1'b0; dirty_mem[i] = 1'b0;
      data_mem[i] = '0; rank_mem[i] = '0;
    end
    for (int i = 0; i < MEM_LINES; i++) backing[i] = '0;

    // after reset everything reads zero; cold miss, clean
    add_row(16'h0000, OP_READ, 8'h00, 1'b1, 64'h0);
    add_row(16'hFFFF, OP_READ, 8'h00, 1'b1, 64'h0);
    add_row(16'h0000, OP_WRITE, 8'hFF, 1'b0, '0);
    add_row(16'h0007, OP_WRITE, 8'hA5, 1'b0, '0);
    add_row(16'h0000, OP_READ, 8'h00, 1'b1, 64'hA5000000_000000FF);
    // fill set 0 with tags 1, 2, 3 and 1FF to evict the dirty tag-0 line (LRU), then tag 4
    add_row(16'h0080, OP_READ, 8'h00, 1'b0, '0);
    add_row(16'h0100, OP_WRITE, 8'h11, 1'b0, '0);
    add_row(16'h0180, OP_READ, 8'h00, 1'b0, '0);
    add_row(16'hFF80, OP_READ, 8'h00, 1'b0, '0);
    add_row(16'h0200, OP_READ, 8'h00, 1'b0, '0);
    add_row(16'h0000, OP_READ, 8'h00, 1'b1, 64'hA5000000_000000FF);
    add_row(16'hFF87, OP_WRITE, 8'h5A, 1'b0, '0);
    add_row(16'hFF80, OP_READ, 8'h00, 1'b0, '0);
    add_row(16'h0100, OP_READ, 8'h00, 1'b0, '0);
    add_row(16'h7FFF, OP_WRITE, 8'h80, 1'b0, '0);
    add_row(16'h7FF8, OP_READ, 8'h00, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].check_line && rows[i].w.operation == OP_READ) begin
        send_word(rows[i].w);
        if (read_results_q[$].line_bytes !== rows[i].line)
          report_mismatch("directed line", read_results_q[$].line_bytes, rows[i].line);
      end else begin
        send_word(rows[i].w);
      end
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // a stretch without idling on either side
      idle_pct  = (n >= 400 && n < 600) ? 0 : 24;
      stall_pct = idle_pct;
      w = random_word();
      send_word(w);
    end
    in_valid  <= 1'b0;
    stall_pct = 24;

    while (read_results_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 20) begin
      @(posedge clk);
      drain++;
    end
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
